// ===== sv/rotary_encoder_full_step_decoder_assert.svh =====
// Assertion macros shared by the rotary encoder decoder RTL.
`ifndef ROTARY_ENCODER_FULL_STEP_DECODER_ASSERT_SVH
`define ROTARY_ENCODER_FULL_STEP_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked only outside reset.
`define RED_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every edge, reset included.
`define RED_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RED_ASSERT(label, clk, rst, prop, msg)
`define RED_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== sv/red_pkg.sv =====
// Types, constants and the full-step state table of the rotary encoder decoder.
package red_pkg;

   // Number of encoders sharing the sample stream
   localparam int NUM_ENCODERS = 4;
   localparam int IDX_W        = 2;
   localparam int TIME_W       = 32;
   localparam int DEBOUNCE_W   = 16;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd20;

   // Request and response tdata widths (padded to whole bytes)
   localparam int REQ_FIELDS_W = IDX_W + 3 + TIME_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = 8;

   // Full-step table states; code 7 is unreachable and acts as start
   typedef enum logic [2:0] {
      ST_START     = 3'd0,
      ST_CW_FINAL  = 3'd1,
      ST_CW_BEGIN  = 3'd2,
      ST_CW_NEXT   = 3'd3,
      ST_CCW_BEGIN = 3'd4,
      ST_CCW_FINAL = 3'd5,
      ST_CCW_NEXT  = 3'd6
   } quad_state_type;

   typedef enum logic [1:0] {
      ROT_NONE = 2'd0,
      ROT_CW   = 2'd1,
      ROT_CCW  = 2'd2
   } rotation_type;

   typedef enum logic [1:0] {
      SW_NONE    = 2'd0,
      SW_PRESS   = 2'd1,
      SW_RELEASE = 2'd2
   } switch_event_type;

   // One decoded request
   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic              switch_level;
      logic              phase_b;
      logic              phase_a;
      logic [IDX_W-1:0]  encoder_index;
   } req_type;

   // Per-encoder state as carried between the state store and the step logic
   typedef struct packed {
      quad_state_type    quad;
      logic              level;
      logic [TIME_W-1:0] change_time;
   } enc_state_type;

   // Table lookup result
   typedef struct packed {
      quad_state_type next;
      rotation_type   dir;
   } step_type;

   // Full-step transition table, indexed by state and code A | B << 1
   function automatic step_type step_lookup(input quad_state_type st, input logic [1:0] code);
      step_type r;
      r.dir  = ROT_NONE;
      r.next = ST_START;
      unique case (st)
         ST_CW_FINAL: begin
            unique case (code)
               2'd0:    r.next = ST_CW_NEXT;
               2'd1:    r.next = ST_START;
               2'd2:    r.next = ST_CW_FINAL;
               default: begin
                  r.next = ST_START;
                  r.dir  = ROT_CW;
               end
            endcase
         end
         ST_CW_BEGIN: begin
            unique case (code)
               2'd0:    r.next = ST_CW_NEXT;
               2'd1:    r.next = ST_CW_BEGIN;
               default: r.next = ST_START;
            endcase
         end
         ST_CW_NEXT: begin
            unique case (code)
               2'd0:    r.next = ST_CW_NEXT;
               2'd1:    r.next = ST_CW_BEGIN;
               2'd2:    r.next = ST_CW_FINAL;
               default: r.next = ST_START;
            endcase
         end
         ST_CCW_BEGIN: begin
            unique case (code)
               2'd0:    r.next = ST_CCW_NEXT;
               2'd2:    r.next = ST_CCW_BEGIN;
               default: r.next = ST_START;
            endcase
         end
         ST_CCW_FINAL: begin
            unique case (code)
               2'd0:    r.next = ST_CCW_NEXT;
               2'd1:    r.next = ST_CCW_FINAL;
               2'd2:    r.next = ST_START;
               default: begin
                  r.next = ST_START;
                  r.dir  = ROT_CCW;
               end
            endcase
         end
         ST_CCW_NEXT: begin
            unique case (code)
               2'd0:    r.next = ST_CCW_NEXT;
               2'd1:    r.next = ST_CCW_FINAL;
               2'd2:    r.next = ST_CCW_BEGIN;
               default: r.next = ST_START;
            endcase
         end
         // start state and the unreachable code
         default: begin
            unique case (code)
               2'd1:    r.next = ST_CW_BEGIN;
               2'd2:    r.next = ST_CCW_BEGIN;
               default: r.next = ST_START;
            endcase
         end
      endcase
      return r;
   endfunction

endpackage

// ===== sv/red_step.sv =====
// Step logic for one sample: table advance and switch debounce.
module red_step (
   input  red_pkg::req_type                    req,
   input  red_pkg::enc_state_type              cur,
   input  logic [red_pkg::DEBOUNCE_W-1:0]      debounce_interval_ms,
   output red_pkg::enc_state_type              nxt,
   output red_pkg::rotation_type               rotation,
   output red_pkg::switch_event_type           switch_event
);

   red_pkg::step_type         step;
   logic [red_pkg::TIME_W-1:0] elapsed;
   logic                      sw_change;

   // Quadrature table advance
   always_comb begin
      step = red_pkg::step_lookup(cur.quad, {req.phase_b, req.phase_a});
   end

   // Debounce: level differs and wrapped elapsed time exceeds the interval
   assign elapsed   = req.now_ms - cur.change_time;
   assign sw_change = (req.switch_level != cur.level) &&
                      (elapsed > {{(red_pkg::TIME_W - red_pkg::DEBOUNCE_W){1'b0}},
                                  debounce_interval_ms});

   // Next state and events
   always_comb begin
      nxt.quad        = step.next;
      nxt.level       = cur.level;
      nxt.change_time = cur.change_time;
      switch_event    = red_pkg::SW_NONE;
      if (sw_change) begin
         nxt.level       = req.switch_level;
         nxt.change_time = req.now_ms;
         switch_event    = req.switch_level ? red_pkg::SW_RELEASE : red_pkg::SW_PRESS;
      end
   end

   assign rotation = step.dir;

endmodule

// ===== sv/rotary_encoder_full_step_decoder.sv =====
// Top level of the full-step rotary encoder decoder with switch debounce.
//
// Channels: requests enter on req_* (one pin sample for one encoder: index,
// phase A/B, switch level, millisecond time); one response per request leaves
// on rsp_* (encoder number, rotation event, switch event). csr_* writes the
// 16-bit debounce interval in ms; it is always ready; the user must write it only
// while idle, which the block itself does not enforce. A request passes the input
// register and then the response register before it is offered on rsp_*.
// Throughput: one request per cycle unless rsp_tready stalls. The per-encoder
// state is read and written in the same stage, so back-to-back samples of one
// encoder see each other's updates without any bubble.
// Reset: all encoders go to the start state, stored switch level released,
// last switch time 0, debounce interval 20 ms; both stages empty.
// Stall: when rsp_tready is low the response register holds; the input
// register keeps one more request and req_tready drops only when both are
// full, so no request is lost or repeated.
module rotary_encoder_full_step_decoder (
   input  logic                              clock,
   input  logic                              reset,
   // request: [1:0] encoder_index, [2] phase_a, [3] phase_b,
   // [4] switch_level, [36:5] now_ms, [39:37] zero
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [red_pkg::REQ_DATA_W-1:0]    req_tdata,
   // response: [1:0] device_number, [3:2] rotation, [5:4] switch_event, [7:6] zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [red_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [red_pkg::DEBOUNCE_W-1:0]    csr_data
);

   `include "rotary_encoder_full_step_decoder_assert.svh"

   logic [red_pkg::DEBOUNCE_W-1:0] interval_ff;

   logic                           s1_valid_ff;
   red_pkg::req_type               s1_req_ff;

   logic                           out_valid_ff;
   logic [red_pkg::IDX_W-1:0]      out_dev_ff;
   red_pkg::rotation_type          out_rot_ff;
   red_pkg::switch_event_type      out_sw_ff;

   red_pkg::quad_state_type        quad_ff  [red_pkg::NUM_ENCODERS];
   logic                           level_ff [red_pkg::NUM_ENCODERS];
   logic [red_pkg::TIME_W-1:0]     time_ff  [red_pkg::NUM_ENCODERS];

   red_pkg::enc_state_type         cur_state;
   red_pkg::enc_state_type         nxt_state;
   red_pkg::rotation_type          step_rot;
   red_pkg::switch_event_type      step_sw;
   logic                           idx_ok;
   logic                           advance;
   logic [red_pkg::IDX_W-1:0]      s1_idx;

   // Handshake: stage 1 moves on when the response register is free
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= red_pkg::DEBOUNCE_RESET;
      end else if (csr_valid && csr_ready) begin
         interval_ff <= csr_data;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_req_ff <= red_pkg::req_type'(req_tdata[red_pkg::REQ_FIELDS_W-1:0]);
      end
   end

   // Read the addressed encoder's state
   assign s1_idx = s1_req_ff.encoder_index;
   assign idx_ok = 32'(s1_idx) < red_pkg::NUM_ENCODERS;

   always_comb begin
      cur_state.quad        = quad_ff[s1_idx];
      cur_state.level       = level_ff[s1_idx];
      cur_state.change_time = time_ff[s1_idx];
   end

   red_step u_step (
      .req                  (s1_req_ff),
      .cur                  (cur_state),
      .debounce_interval_ms (interval_ff),
      .nxt                  (nxt_state),
      .rotation             (step_rot),
      .switch_event         (step_sw)
   );

   // Per-encoder state write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < red_pkg::NUM_ENCODERS; k++) begin
            quad_ff[k]  <= red_pkg::ST_START;
            level_ff[k] <= 1'b1;
            time_ff[k]  <= '0;
         end
      end else if (advance && idx_ok) begin
         quad_ff[s1_idx]  <= nxt_state.quad;
         level_ff[s1_idx] <= nxt_state.level;
         time_ff[s1_idx]  <= nxt_state.change_time;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_dev_ff <= s1_idx;
         out_rot_ff <= idx_ok ? step_rot : red_pkg::ROT_NONE;
         out_sw_ff  <= idx_ok ? step_sw  : red_pkg::SW_NONE;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_sw_ff, out_rot_ff, out_dev_ff};

   // Checks
   `RED_ASSERT_ALWAYS(a_reset_empty, clock,
      reset |=> (!rsp_tvalid && !s1_valid_ff), "pipeline not empty after reset")
   `RED_ASSERT(a_rot_code, clock, reset,
      rsp_tvalid |-> (rsp_tdata[3:2] != 2'd3), "invalid rotation code")
   `RED_ASSERT(a_sw_stored, clock, reset,
      (advance && idx_ok && (step_sw != red_pkg::SW_NONE)) |=>
      (level_ff[$past(s1_idx)] == $past(s1_req_ff.switch_level)),
      "switch level not stored with its event")
   `RED_ASSERT(a_rot_start, clock, reset,
      (advance && idx_ok && (step_rot != red_pkg::ROT_NONE)) |=>
      (quad_ff[$past(s1_idx)] == red_pkg::ST_START),
      "rotation reported without return to start")

endmodule
